### rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Package for the point list engine: command and status codes, the
// per-command control group broadcast to the cell row, and default sizes.
// No dependencies.
package ple_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_COORD_WIDTH = 16;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_READ      = 3'd3,
    CMD_SET_COUNT = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e_t;

  // Control group for one accepted word; each flag is set only when the
  // command was accepted and passed its checks.
  typedef struct packed {
    logic append;
    logic insert;
    logic remove;
    logic fill;
  } ple_op_t;

endpackage

### rtl/core/ple_cell.sv
`timescale 1ns / 1ps
// One cell of the point row: holds one point and loads from the input,
// from its left or right neighbor, or zero, as the broadcast command says.
// Depends on ple_pkg.
module ple_cell #(
  parameter int IDX         = 0,
  parameter int CNT_W       = 7,
  parameter int COORD_WIDTH = ple_pkg::DEF_COORD_WIDTH
) (
  input  logic                   clk,
  input  ple_pkg::ple_op_t       op,
  input  logic [CNT_W-1:0]       pos,
  input  logic [CNT_W-1:0]       count,
  input  logic [CNT_W-1:0]       ncount,
  input  logic [COORD_WIDTH-1:0] wr_x,
  input  logic [COORD_WIDTH-1:0] wr_y,
  input  logic [COORD_WIDTH-1:0] left_x,
  input  logic [COORD_WIDTH-1:0] left_y,
  input  logic [COORD_WIDTH-1:0] right_x,
  input  logic [COORD_WIDTH-1:0] right_y,
  output logic [COORD_WIDTH-1:0] x_q,
  output logic [COORD_WIDTH-1:0] y_q
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [COORD_WIDTH-1:0] x_r, x_nxt;
  logic [COORD_WIDTH-1:0] y_r, y_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (op.append && (count == MY_IDX)) begin
      x_nxt = wr_x;
      y_nxt = wr_y;
    end else if (op.insert && (pos == MY_IDX)) begin
      x_nxt = wr_x;
      y_nxt = wr_y;
    end else if (op.insert && (pos < MY_IDX)) begin
      x_nxt = left_x;
      y_nxt = left_y;
    end else if (op.remove && (pos <= MY_IDX)) begin
      x_nxt = right_x;
      y_nxt = right_y;
    end else if (op.fill && (MY_IDX >= count) && (MY_IDX < ncount)) begin
      x_nxt = '0;
      y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x_q = x_r;
  assign y_q = y_r;

endmodule

### rtl/core/ple_chain.sv
`timescale 1ns / 1ps
// Row of CAPACITY point cells wired to their neighbors, plus the read
// select that picks one cell by position. Depends on ple_pkg and ple_cell.
module ple_chain #(
  parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
  parameter int COORD_WIDTH = ple_pkg::DEF_COORD_WIDTH,
  parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  ple_pkg::ple_op_t       op,
  input  logic [CNT_W-1:0]       pos,
  input  logic [CNT_W-1:0]       count,
  input  logic [CNT_W-1:0]       ncount,
  input  logic [COORD_WIDTH-1:0] wr_x,
  input  logic [COORD_WIDTH-1:0] wr_y,
  output logic [COORD_WIDTH-1:0] rd_x,
  output logic [COORD_WIDTH-1:0] rd_y
);
  import ple_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [COORD_WIDTH-1:0] cell_x [CAPACITY];
  logic [COORD_WIDTH-1:0] cell_y [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // The end cells have no neighbor on one side; they see their own value.
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == CAPACITY - 1) ? i : i + 1;
    ple_cell #(
      .IDX         (i),
      .CNT_W       (CNT_W),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .pos     (pos),
      .count   (count),
      .ncount  (ncount),
      .wr_x    (wr_x),
      .wr_y    (wr_y),
      .left_x  (cell_x[L]),
      .left_y  (cell_y[L]),
      .right_x (cell_x[R]),
      .right_y (cell_y[R]),
      .x_q     (cell_x[i]),
      .y_q     (cell_y[i])
    );
  end

  logic pos_in_row;
  assign pos_in_row = (pos < CNT_W'(CAPACITY));

  always_comb begin
    rd_x = '0;
    rd_y = '0;
    if (pos_in_row) begin
      rd_x = cell_x[pos[IDX_W-1:0]];
      rd_y = cell_y[pos[IDX_W-1:0]];
    end
  end

endmodule

### rtl/core/point_list_engine.sv
`timescale 1ns / 1ps
// Point list engine: ordered list of up to CAPACITY points held in a row of cells.
// The result word for a command is registered and appears in the cycle after the command word is taken.
// Throughput: one command word per cycle unless a held result stalls input; insert and remove shift all cells together.
// A held result stalls input only while out_tready is low.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared and are only read after being written.
module point_list_engine #(
  parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
  parameter int COORD_WIDTH = ple_pkg::DEF_COORD_WIDTH,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int IN_DW       = ((2 * CNT_W + 2 * COORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_DW      = ((2 * COORD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // Fields from bit 0 up: pos_index, new_count, in_x, in_y, zero fill.
  input  logic [IN_DW-1:0]  in_tdata,
  // Fields: cmd.
  input  logic [2:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // Fields from bit 0 up: out_x, out_y, count_now, zero fill.
  output logic [OUT_DW-1:0] out_tdata,
  // Fields from bit 0 up: found, status.
  output logic [2:0]        out_tuser
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // Unpack the command word.
  logic [CNT_W-1:0]       pos_index;
  logic [CNT_W-1:0]       new_count;
  logic [COORD_WIDTH-1:0] in_x;
  logic [COORD_WIDTH-1:0] in_y;
  cmd_e_t                 cmd;

  assign pos_index = in_tdata[CNT_W-1:0];
  assign new_count = in_tdata[2*CNT_W-1:CNT_W];
  assign in_x      = in_tdata[2*CNT_W +: COORD_WIDTH];
  assign in_y      = in_tdata[2*CNT_W+COORD_WIDTH +: COORD_WIDTH];
  assign cmd       = cmd_e_t'(in_tuser);

  // The output register separates the two sides: a new word is taken
  // whenever the register is empty or its word leaves in this cycle.
  logic in_fire;
  logic out_valid_r, out_valid_nxt;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full;
  assign full = (count_r == CAP_C);

  // Decode: checks, status, the cell control group and the next count.
  ple_op_t   op;
  status_e_t status_nxt;
  logic      found_nxt;
  always_comb begin
    op         = '0;
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    count_nxt  = count_r;
    case (cmd)
      CMD_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op.append = in_fire;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        // A full list is reported before a bad position.
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_index > count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          op.insert = in_fire;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_index >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          op.remove = in_fire;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_index >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          found_nxt = 1'b1;
        end
      end
      CMD_SET_COUNT: begin
        if (new_count > CAP_C) begin
          status_nxt = ST_RANGE;
        end else begin
          // Cells between the old and new count become zero points.
          op.fill   = in_fire;
          count_nxt = new_count;
        end
      end
      default: begin
        // Undefined commands do nothing and report ok.
        status_nxt = ST_OK;
      end
    endcase
  end

  logic [COORD_WIDTH-1:0] rd_x, rd_y;

  ple_chain #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (COORD_WIDTH),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk    (clk),
    .op     (op),
    .pos    (pos_index),
    .count  (count_r),
    .ncount (new_count),
    .wr_x   (in_x),
    .wr_y   (in_y),
    .rd_x   (rd_x),
    .rd_y   (rd_y)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload; coordinates are zero unless a read found its entry.
  logic [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0]       count_now_r;
  logic                   found_r;
  status_e_t              status_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_x_r     <= found_nxt ? rd_x : '0;
      out_y_r     <= found_nxt ? rd_y : '0;
      found_r     <= found_nxt;
      count_now_r <= count_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({count_now_r, out_y_r, out_x_r});
  assign out_tuser  = {status_r, found_r};

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  // A rejected command leaves the count unchanged.
  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (status_nxt != ST_OK)) |=> (count_r == $past(count_r)))
    else $error("rejected command changed the count");

  // A successful append grows the list by one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_APPEND) && !full) |=> (count_r == $past(count_r) + 1'b1))
    else $error("append did not grow the list");

  // A found entry is always reported with ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (status_r == ST_OK))
    else $error("found flag with error status");

endmodule
